/* sv/integer_alu_div_mod_pow_macros.svh */
// Assertion macros used by the integer ALU controller.
`ifndef INTEGER_ALU_DIV_MOD_POW_MACROS_SVH
`define INTEGER_ALU_DIV_MOD_POW_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define IADMP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define IADMP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* sv/iadmp_pkg.sv */
// Package with operation codes, error codes and the controller command and status structs.
`default_nettype none
package iadmp_pkg;
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MOD = 3'd4;
  localparam logic [2:0] OP_POW = 3'd5;
  localparam logic [2:0] OP_CMP = 3'd6;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_DIV0 = 2'd1;
  localparam logic [1:0] ERR_MOD0 = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture operands and set up the operation
    logic step;   // run one divider iteration or one phase of a multiplier pass
    logic finish; // form the final result into the output register
  } iadmp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic iterate; // the loaded operation needs iterations
    logic last;    // the current iteration is the final one
  } iadmp_sts_t;
endpackage
`default_nettype wire

/* sv/iadmp_datapath.sv */
// Datapath: operand registers, shift-subtract divider and square-and-multiply loop.
`default_nettype none
module iadmp_datapath #(
  parameter int DATA_WIDTH = 64
) (
  input  wire                        clk,
  input  wire logic [2:0]            kind,
  input  wire logic [63:0]           left_operand,
  input  wire logic [63:0]           right_operand,
  input  wire iadmp_pkg::iadmp_cmd_t cmd,
  output iadmp_pkg::iadmp_sts_t      sts,
  output logic [63:0]                result_value,
  output logic [1:0]                 error_code
);
  localparam int CW = $clog2(DATA_WIDTH + 1);
  localparam logic [CW-1:0] LAST_COUNT = CW'(DATA_WIDTH - 1);

  typedef logic [DATA_WIDTH-1:0] word_t;

  logic [2:0]    op;
  word_t         a, b;
  word_t         rem, quo, dvs;   // divider: partial remainder, quotient, divisor
  word_t         acc, base, expo; // power loop; multiply runs one pass of it
  logic          neg_a, neg_b;
  logic [CW-1:0] count;
  logic [1:0]    phase;           // sub-cycle of one multiplier pass
  logic [63:0]   pacc, pbase;     // partial products of the current pass

  word_t         in_a, in_b, mag_a, mag_b, rem_sh, res;
  logic [DATA_WIDTH:0] trial;
  logic          loop_op, mul_op, pass_end, lt, eq;
  logic [1:0]    err;
  logic [CW-1:0] last_count;
  logic [63:0]   acc_w, base_w, mul_p0, mul_p1;
  logic [31:0]   mul_x0, mul_y0, mul_y1;

  assign in_a  = left_operand[DATA_WIDTH-1:0];
  assign in_b  = right_operand[DATA_WIDTH-1:0];
  assign mag_a = in_a[DATA_WIDTH-1] ? word_t'(-in_a) : in_a;
  assign mag_b = in_b[DATA_WIDTH-1] ? word_t'(-in_b) : in_b;

  // Division iteration: shift in the next dividend bit and try a subtraction.
  assign rem_sh = {rem[DATA_WIDTH-2:0], quo[DATA_WIDTH-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dvs};

  // Power iteration: both wrapped products are built from 32x32 partial
  // products over the phases of one pass. The first phase takes the low halves,
  // the second the cross terms with the high half of base, the third the cross
  // term with the high half of acc. The square needs its cross term only once,
  // doubled.
  assign acc_w  = 64'(acc);
  assign base_w = 64'(base);

  always_comb begin
    mul_x0 = acc_w[31:0];
    mul_y0 = base_w[31:0];
    mul_y1 = base_w[31:0];
    case (phase)
      2'd1: begin
        mul_y0 = base_w[63:32];
        mul_y1 = base_w[63:32];
      end
      2'd2: mul_x0 = acc_w[63:32];
      default: mul_x0 = acc_w[31:0];
    endcase
  end

  assign mul_p0 = mul_x0 * mul_y0;
  assign mul_p1 = base_w[31:0] * mul_y1;

  assign mul_op  = (op == iadmp_pkg::OP_MUL) || (op == iadmp_pkg::OP_POW);
  assign loop_op = (op == iadmp_pkg::OP_DIV) || (op == iadmp_pkg::OP_MOD) || mul_op;
  assign pass_end   = !mul_op || (phase == 2'd2);
  assign last_count = (op == iadmp_pkg::OP_MUL) ? '0 : LAST_COUNT;
  assign sts.iterate = loop_op;
  assign sts.last    = pass_end && (count == last_count);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= kind;
      a     <= in_a;
      b     <= in_b;
      neg_a <= in_a[DATA_WIDTH-1];
      neg_b <= in_b[DATA_WIDTH-1];
      count <= '0;
      phase <= '0;
      rem   <= '0;
      quo   <= mag_a;
      dvs   <= mag_b;
      // A plain multiply is a single pass with an exponent of one.
      if (kind == iadmp_pkg::OP_MUL) begin
        acc  <= in_a;
        base <= in_b;
        expo <= word_t'(1);
      end else begin
        acc  <= word_t'(1);
        base <= in_a;
        expo <= in_b;
      end
    end else if (cmd.step) begin
      if (mul_op) begin
        phase <= (phase == 2'd2) ? 2'd0 : phase + 2'd1;
        case (phase)
          2'd0: begin
            pacc  <= mul_p0;
            pbase <= mul_p1;
          end
          2'd1: begin
            pacc[63:32]  <= pacc[63:32] + mul_p0[31:0];
            pbase[63:32] <= pbase[63:32] + {mul_p1[30:0], 1'b0};
          end
          default: begin
            count <= count + CW'(1);
            if (expo[0]) begin
              acc <= word_t'({pacc[63:32] + mul_p0[31:0], pacc[31:0]});
            end
            base <= word_t'(pbase);
            expo <= expo >> 1;
          end
        endcase
      end else begin
        count <= count + CW'(1);
        if (!trial[DATA_WIDTH]) begin
          rem <= trial[DATA_WIDTH-1:0];
        end else begin
          rem <= rem_sh;
        end
        quo <= {quo[DATA_WIDTH-2:0], ~trial[DATA_WIDTH]};
      end
    end
  end

  assign lt = $signed(a) < $signed(b);
  assign eq = (a == b);

  always_comb begin
    res = '0;
    err = iadmp_pkg::ERR_NONE;
    case (op)
      iadmp_pkg::OP_ADD: res = a + b;
      iadmp_pkg::OP_SUB: res = a - b;
      iadmp_pkg::OP_MUL: res = acc;
      iadmp_pkg::OP_DIV: begin
        if (b == '0) begin
          err = iadmp_pkg::ERR_DIV0;
        end else begin
          res = (neg_a != neg_b) ? word_t'(-quo) : quo;
        end
      end
      iadmp_pkg::OP_MOD: begin
        if (b == '0) begin
          err = iadmp_pkg::ERR_MOD0;
        end else begin
          res = neg_a ? word_t'(-rem) : rem;
        end
      end
      iadmp_pkg::OP_POW: begin
        if (a == word_t'(1)) begin
          res = word_t'(1);
        end else if (a == '1) begin
          res = b[0] ? '1 : word_t'(1);
        end else if (b == word_t'(1)) begin
          res = a;
        end else if (b == '0) begin
          res = word_t'(1);
        end else if (b[DATA_WIDTH-1]) begin
          res = '0;
        end else begin
          res = acc;
        end
      end
      iadmp_pkg::OP_CMP: res = lt ? '1 : (eq ? '0 : word_t'(1));
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result_value <= {{(64 - DATA_WIDTH){res[DATA_WIDTH-1]}}, res};
      error_code   <= err;
    end
  end
endmodule
`default_nettype wire

/* sv/iadmp_ctrl.sv */
// Controller state machine: sequences load, iterations, finish and output handshake.
`default_nettype none
`include "integer_alu_div_mod_pow_macros.svh"
module iadmp_ctrl (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire                        out_ready,
  input  wire iadmp_pkg::iadmp_sts_t sts,
  output iadmp_pkg::iadmp_cmd_t      cmd
);
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_LOOP   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state, state_next;
  logic       out_valid_next;

  // A new item is taken once the controller is idle and the output register is free or being emptied.
  assign in_ready   = !rst && (state == S_IDLE) && (!out_valid || out_ready);
  assign cmd.load   = in_valid && in_ready;
  assign cmd.step   = (state == S_LOOP);
  assign cmd.finish = (state == S_FINISH);

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE:   if (cmd.load) state_next = S_DECIDE;
      S_DECIDE: state_next = sts.iterate ? S_LOOP : S_FINISH;
      S_LOOP:   if (sts.last) state_next = S_FINISH;
      S_FINISH: begin
        state_next     = S_IDLE;
        out_valid_next = 1'b1;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `IADMP_ASSERT_NEXT(a_load_decide, clk, rst, cmd.load, state == S_DECIDE, "load not followed by decide")
  `IADMP_ASSERT_NEXT(a_finish_valid, clk, rst, cmd.finish, out_valid, "finish did not raise valid")
  `IADMP_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.finish, !out_valid, "result overwritten")
endmodule
`default_nettype wire

/* sv/integer_alu_div_mod_pow.sv */
// Top level of the signed integer ALU with divide, modulo and power.
`default_nettype none
// Signed integer ALU: one transaction in, one transaction out. Add, subtract,
// compare and the unused operation code need no iterations: after acceptance
// the controller passes through its decide and finish states to a valid
// result. Multiply runs one pass that builds the wrapped product from 32x32
// partial products. Divide and modulo run the restoring divider, one quotient
// bit per cycle. Power runs one square-and-multiply pass per exponent bit. The
// block holds one operation at a time; a new input transaction is accepted
// once the previous result has been taken or is being taken. Operands use
// their low DATA_WIDTH bits as signed values; the result is sign-extended to
// 64 bits.
// A zero divisor gives result 0 with error 1 (divide) or 2 (modulo).
module integer_alu_div_mod_pow #(
  parameter int DATA_WIDTH = 64
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [135:0] s_axis_tdata,  // kind[2:0], left_operand[66:3], right_operand[130:67]
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [71:0]  m_axis_tdata   // result_value[63:0], error_code[65:64]
);
  iadmp_pkg::iadmp_cmd_t cmd;
  iadmp_pkg::iadmp_sts_t sts;
  logic [63:0] result_value;
  logic [1:0]  error_code;

  iadmp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  iadmp_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk           (clk),
    .kind          (s_axis_tdata[2:0]),
    .left_operand  (s_axis_tdata[66:3]),
    .right_operand (s_axis_tdata[130:67]),
    .cmd           (cmd),
    .sts           (sts),
    .result_value  (result_value),
    .error_code    (error_code)
  );

  assign m_axis_tdata = {6'd0, error_code, result_value};
endmodule
`default_nettype wire
